FILE: rtl/bba_pkg.sv
// Shared constants, types and sizing functions for the buddy block allocator.
package bba_pkg;

    localparam int MIN_BLOCK_LOG2 = 7;
    localparam int MAX_ORDER      = 10;
    localparam int TOP_BLOCKS     = 32;

    localparam logic [6:0]  HEADER_RESET = 7'd48;
    localparam logic [26:0] MAX_REQUEST  = 27'd100000000;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_TOO_BIG   = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_NOT_ALLOC = 3'd4
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SIZE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT_RD,
        S_SPLIT_WR,
        S_MARK_WR,
        S_FREE_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_SET_RD,
        S_SET_WR,
        S_DONE
    } state_t;

    // Sizing result handed from the sizer to the controller
    typedef struct packed {
        logic       bad_size;
        logic       too_big;
        logic [3:0] need;
    } size_info_t;

    // 32-bit free-map words used by order k
    function automatic int order_words(int top, int maxo, int k);
        return ((top << (maxo - k)) + 31) >> 5;
    endfunction

    // First free-map word of order k
    function automatic int word_base(int top, int maxo, int k);
        int b;
        int j;
        b = 0;
        for (j = 0; j < k; j++)
            b = b + order_words(top, maxo, j);
        return b;
    endfunction

endpackage

FILE: rtl/buddy_block_allocator.sv
// Buddy allocator top level: free-map and block-tag memories with sequencer.
//
// Channel   Dir  tdata (low bit up)                           tuser
// s_axis    in   request_size[26:0], block_offset[41:27]      cmd
// m_axis    out  granted_offset, granted_order, count         status
// cfg       in   cfg_wdata = header_bytes (write on cfg_we)   -
//
// One request at a time. Allocate: scan free-map words (32 blocks a word) from the
// needed order upward, then split down level by level. Free: merge with free buddies
// level by level, then set the final free bit. A rejected request goes straight
// to the result. The free-map memory has a single read port.
// After reset a clearing pass initialises every free-map word and block tag
// before the first request is taken.
// A finished result waits in the output register; a new request is taken
// meanwhile.
module buddy_block_allocator #(
    parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2,
    parameter int MAX_ORDER      = bba_pkg::MAX_ORDER,
    parameter int TOP_BLOCKS     = bba_pkg::TOP_BLOCKS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // request_size[26:0], block_offset[41:27]
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // granted_offset, granted_order, free_block_count
    output logic [2:0]  m_axis_tuser,   // status
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    localparam int HEAP_UNITS = TOP_BLOCKS << MAX_ORDER;
    localparam int UNIT_W     = $clog2(HEAP_UNITS);
    localparam int FW         = bba_pkg::word_base(TOP_BLOCKS, MAX_ORDER, MAX_ORDER + 1);
    localparam int FA         = $clog2(FW);
    localparam int CNT_W      = $clog2(HEAP_UNITS + 1);
    localparam int CLR_N      = (HEAP_UNITS > FW) ? HEAP_UNITS : FW;
    localparam int CLR_W      = $clog2(CLR_N);

    // Per-order word bases and word counts, fixed at elaboration
    logic [FA-1:0] base_tab [MAX_ORDER+1];
    logic [FA:0]   wcnt_tab [MAX_ORDER+1];

    for (genvar g = 0; g <= MAX_ORDER; g++)
    begin : g_tab
        assign base_tab[g] = FA'(bba_pkg::word_base(TOP_BLOCKS, MAX_ORDER, g));
        assign wcnt_tab[g] = (FA+1)'(bba_pkg::order_words(TOP_BLOCKS, MAX_ORDER, g));
    end

    // Memories
    logic [31:0]   fmem [FW];
    logic [4:0]    mmem [HEAP_UNITS];
    logic          f_we;
    logic [FA-1:0] f_waddr;
    logic [FA-1:0] f_raddr;
    logic [31:0]   f_wdata;
    logic [31:0]   f_rdata;
    logic              m_we;
    logic [UNIT_W-1:0] m_waddr;
    logic [UNIT_W-1:0] m_raddr;
    logic [4:0]        m_wdata;
    logic [4:0]        m_rdata;

    always_ff @(posedge clk)
    begin
        if (f_we)
            fmem[f_waddr] <= f_wdata;
        f_rdata <= fmem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
            mmem[m_waddr] <= m_wdata;
        m_rdata <= mmem[m_raddr];
    end

    // Control and payload registers
    bba_pkg::state_t  state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [6:0]       hdr_reg;
    logic             out_valid_reg, out_valid_next;
    logic [UNIT_W-1:0] off_reg, off_next;
    logic [3:0]       k_reg, k_next;
    logic [FA-1:0]    w_reg, w_next;
    logic             bad_off_reg, bad_off_next;
    bba_pkg::status_t res_status_reg, res_status_next;
    logic [UNIT_W-1:0] res_off_reg, res_off_next;
    logic [3:0]       res_ord_reg, res_ord_next;
    bba_pkg::status_t out_status_reg;
    logic [14:0]      out_off_reg;
    logic [3:0]       out_ord_reg;
    logic [15:0]      out_cnt_reg;

    bba_pkg::size_info_t info;
    logic                in_acc;
    logic                load_out;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    bba_sizer #(
        .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
        .MAX_ORDER      (MAX_ORDER)
    ) u_sizer (
        .clk          (clk),
        .load         (in_acc),
        .request_size (s_axis_tdata[26:0]),
        .header_bytes (hdr_reg),
        .info_reg     (info)
    );

    // Free-map addressing for split, merge and final set
    logic [UNIT_W-1:0] unit_bit;
    logic [UNIT_W-1:0] sel_off;
    logic [31:0]       idx;
    logic [FA-1:0]     map_addr;
    logic [4:0]        map_bit;
    logic [31:0]       map_mask;

    always_comb
    begin
        unit_bit = UNIT_W'(1) << k_reg;
        case (state_reg)
            bba_pkg::S_SPLIT_RD, bba_pkg::S_SPLIT_WR:   sel_off = off_reg | unit_bit;
            bba_pkg::S_MERGE_RD, bba_pkg::S_MERGE_CHK:  sel_off = off_reg ^ unit_bit;
            default:                                    sel_off = off_reg;
        endcase
        idx      = 32'(sel_off) >> k_reg;
        map_addr = base_tab[k_reg] + FA'(idx >> 5);
        map_bit  = idx[4:0];
        map_mask = 32'd1 << map_bit;
    end

    // Lowest set bit of a scanned word
    logic [4:0] low_bit;

    always_comb
    begin
        low_bit = 5'd0;
        for (int b = 31; b >= 0; b--)
            if (f_rdata[b])
                low_bit = 5'(b);
    end

    // Initial free-map word during the clearing pass
    logic [FA-1:0] clr_faddr;
    logic [31:0]   clr_word;
    logic [FA-1:0] top_w;

    always_comb
    begin
        clr_faddr = clr_reg[FA-1:0];
        top_w     = clr_faddr - base_tab[MAX_ORDER];
        for (int b = 0; b < 32; b++)
            clr_word[b] = (clr_faddr >= base_tab[MAX_ORDER]) &&
                          (((32'(top_w) << 5) + 32'(b)) < 32'(TOP_BLOCKS));
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        off_next        = off_reg;
        k_next          = k_reg;
        w_next          = w_reg;
        bad_off_next    = bad_off_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_ord_next    = res_ord_reg;
        f_we            = 1'b0;
        f_waddr         = map_addr;
        f_raddr         = map_addr;
        f_wdata         = f_rdata;
        m_we            = 1'b0;
        m_waddr         = off_reg;
        m_raddr         = off_reg;
        m_wdata         = 5'd0;
        s_axis_tready   = 1'b0;
        load_out        = 1'b0;

        unique case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                f_we    = 32'(clr_reg) < 32'(FW);
                f_waddr = clr_faddr;
                f_wdata = clr_word;
                m_we    = 32'(clr_reg) < 32'(HEAP_UNITS);
                m_waddr = clr_reg[UNIT_W-1:0];
                m_wdata = 5'd0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == 32'(CLR_N - 1))
                    state_next = bba_pkg::S_IDLE;
            end

            bba_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                m_raddr       = UNIT_W'(s_axis_tdata[41:27]);
                if (in_acc)
                begin
                    off_next     = UNIT_W'(s_axis_tdata[41:27]);
                    bad_off_next = 32'(s_axis_tdata[41:27]) >= 32'(HEAP_UNITS);
                    if (s_axis_tuser == bba_pkg::CMD_FREE)
                        state_next = bba_pkg::S_FREE_CHK;
                    else
                        state_next = bba_pkg::S_SIZE;
                end
            end

            bba_pkg::S_SIZE:
            begin
                k_next = info.need;
                w_next = '0;
                if (info.bad_size)
                begin
                    res_status_next = bba_pkg::ST_BAD_SIZE;
                    state_next      = bba_pkg::S_DONE;
                end
                else if (info.too_big)
                begin
                    res_status_next = bba_pkg::ST_TOO_BIG;
                    state_next      = bba_pkg::S_DONE;
                end
                else
                    state_next = bba_pkg::S_SCAN_RD;
            end

            bba_pkg::S_SCAN_RD:
            begin
                f_raddr    = base_tab[k_reg] + w_reg;
                state_next = bba_pkg::S_SCAN_CHK;
            end

            bba_pkg::S_SCAN_CHK:
            begin
                f_waddr = base_tab[k_reg] + w_reg;
                f_wdata = f_rdata & ~(32'd1 << low_bit);
                if (f_rdata != 32'd0)
                begin
                    f_we     = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    off_next = UNIT_W'({w_reg, low_bit}) << k_reg;
                    if (k_reg == info.need)
                        state_next = bba_pkg::S_MARK_WR;
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        state_next = bba_pkg::S_SPLIT_RD;
                    end
                end
                else if ((FA+1)'(w_reg) == wcnt_tab[k_reg] - 1'b1)
                begin
                    w_next = '0;
                    if (32'(k_reg) == 32'(MAX_ORDER))
                    begin
                        res_status_next = bba_pkg::ST_NO_SPACE;
                        state_next      = bba_pkg::S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = bba_pkg::S_SCAN_RD;
                    end
                end
                else
                begin
                    w_next     = w_reg + 1'b1;
                    state_next = bba_pkg::S_SCAN_RD;
                end
            end

            bba_pkg::S_SPLIT_RD:
                state_next = bba_pkg::S_SPLIT_WR;

            // Upper half at this order becomes free
            bba_pkg::S_SPLIT_WR:
            begin
                f_we     = 1'b1;
                f_wdata  = f_rdata | map_mask;
                cnt_next = cnt_reg + 1'b1;
                if (k_reg == info.need)
                    state_next = bba_pkg::S_MARK_WR;
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = bba_pkg::S_SPLIT_RD;
                end
            end

            bba_pkg::S_MARK_WR:
            begin
                m_we            = 1'b1;
                m_wdata         = {1'b1, info.need};
                res_status_next = bba_pkg::ST_OK;
                res_off_next    = off_reg;
                res_ord_next    = info.need;
                state_next      = bba_pkg::S_DONE;
            end

            bba_pkg::S_FREE_CHK:
            begin
                if (bad_off_reg || !m_rdata[4])
                begin
                    res_status_next = bba_pkg::ST_NOT_ALLOC;
                    state_next      = bba_pkg::S_DONE;
                end
                else
                begin
                    m_we    = 1'b1;
                    m_wdata = 5'd0;
                    if (32'(m_rdata[3:0]) > 32'(MAX_ORDER))
                        k_next = 4'(MAX_ORDER);
                    else
                        k_next = m_rdata[3:0];
                    state_next = bba_pkg::S_MERGE_RD;
                end
            end

            bba_pkg::S_MERGE_RD:
            begin
                if (32'(k_reg) >= 32'(MAX_ORDER))
                    state_next = bba_pkg::S_SET_RD;
                else
                    state_next = bba_pkg::S_MERGE_CHK;
            end

            // Absorb a free buddy and climb one order
            bba_pkg::S_MERGE_CHK:
            begin
                f_wdata = f_rdata & ~map_mask;
                if (f_rdata[map_bit])
                begin
                    f_we       = 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    off_next   = off_reg & ~unit_bit;
                    k_next     = k_reg + 1'b1;
                    state_next = bba_pkg::S_MERGE_RD;
                end
                else
                    state_next = bba_pkg::S_SET_RD;
            end

            bba_pkg::S_SET_RD:
                state_next = bba_pkg::S_SET_WR;

            bba_pkg::S_SET_WR:
            begin
                f_we            = 1'b1;
                f_wdata         = f_rdata | map_mask;
                cnt_next        = cnt_reg + 1'b1;
                res_status_next = bba_pkg::ST_OK;
                res_off_next    = off_reg;
                res_ord_next    = k_reg;
                state_next      = bba_pkg::S_DONE;
            end

            bba_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = bba_pkg::S_IDLE;
                end
            end

            default:
                state_next = bba_pkg::S_IDLE;
        endcase
    end

    // Output slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tvalid && m_axis_tready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= CNT_W'(TOP_BLOCKS);
            hdr_reg       <= bba_pkg::HEADER_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                hdr_reg <= cfg_wdata;
        end
    end

    // Payload registers; an error reports offset and order zero
    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        k_reg          <= k_next;
        w_reg          <= w_next;
        bad_off_reg    <= bad_off_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_ord_reg    <= res_ord_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_off_reg    <= (res_status_reg == bba_pkg::ST_OK) ? 15'(res_off_reg) : 15'd0;
            out_ord_reg    <= (res_status_reg == bba_pkg::ST_OK) ? res_ord_reg : 4'd0;
            out_cnt_reg    <= 16'(cnt_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {5'd0, out_cnt_reg, out_ord_reg, out_off_reg};

endmodule

FILE: rtl/bba_sizer.sv
// Request sizing: header add, order lookup and range checks, registered.
module bba_sizer #(
    parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2,
    parameter int MAX_ORDER      = bba_pkg::MAX_ORDER
) (
    input  logic                clk,
    input  logic                load,
    input  logic [26:0]         request_size,
    input  logic [6:0]          header_bytes,
    output bba_pkg::size_info_t info_reg
);

    logic [27:0]         total;
    logic [MAX_ORDER:0]  exceed;
    logic [3:0]          need;
    bba_pkg::size_info_t info_next;

    // One threshold compare per order
    always_comb
    begin
        total = {1'b0, request_size} + 28'(header_bytes);
        for (int k = 0; k <= MAX_ORDER; k++)
            exceed[k] = total > (28'(1) << (MIN_BLOCK_LOG2 + k));
    end

    // Needed order is the number of thresholds passed below the top
    always_comb
    begin
        need = 4'd0;
        for (int k = 0; k < MAX_ORDER; k++)
            need = need + 4'(exceed[k]);
        info_next.need     = need;
        info_next.too_big  = exceed[MAX_ORDER];
        info_next.bad_size = (request_size == 27'd0) || (request_size > bba_pkg::MAX_REQUEST);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            info_reg <= info_next;
    end

endmodule

FILE: rtl/bba_checker.sv
// Port-level checks for the buddy block allocator, bound to the top level.
module bba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic ok;
    assign ok = m_axis_tuser == bba_pkg::ST_OK;

    // Errors report a zero block
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !ok) |-> (m_axis_tdata[18:0] == 19'd0))
        else $error("error result with nonzero block");

    // Granted order never exceeds the top order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ok) |-> (32'(m_axis_tdata[18:15]) <= 32'(bba_pkg::MAX_ORDER)))
        else $error("granted order above top order");

    // Granted block is aligned to its size
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ok) |->
        ((m_axis_tdata[14:0] & ((15'd1 << m_axis_tdata[18:15]) - 15'd1)) == 15'd0))
        else $error("granted block misaligned");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
